>>> design/hll_pkg.sv
// Shared constants for the HyperLogLog distinct counter.
// Hash constants, fixed-point constants and function codes.
// No dependencies.
package hll_pkg;

  localparam int PRECISION_BITS_DEF = 10;

  localparam logic [31:0] HASH_SEED = 32'h9e3779b9;
  localparam logic [31:0] HASH_MUL1 = 32'h85ebca6b;
  localparam logic [31:0] HASH_MUL2 = 32'hc2b2ae35;
  localparam logic [31:0] LN2_Q32   = 32'hB17217F8;
  localparam logic [30:0] EST_MAX   = 31'h7FFFFFFF;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

endpackage

>>> design/hyperloglog_ipv4_distinct_counter_core.sv
// HyperLogLog distinct counter for IPv4 source addresses, top level.
// Uses hll_pkg; holds the rank memory, one shared 32x32 multiplier and its sequencer.
//
// Input channel s_axis: tuser carries the function (add, query, clear), tdata the
// address. Output channel m_axis: one estimate word for each query.
// One item at a time: s_axis_tready is high only when the sequencer is idle.
// Add: after accept, two hash multiplies on the shared multiplier (S_H1, S_H2),
// register read (S_H3), max and write back (S_H4).
// Clear: one memory entry per cycle, over all 2^PRECISION_BITS entries.
// Query: a walk of the memory (S_WALK, S_WEND), the divisor formed on the
// multiplier (S_DMUL, S_DSUM), bit-serial division giving 2*PRECISION_BITS + 46
// quotient bits, rounding (S_FIN), and in the small range a log (a setup step,
// S_LOG0, then 32 squarings and the ln 2 products in S_LN1 to S_LN3).
// The estimate is then held in the output register.
// After reset a clearing pass zeroes every memory entry,
// with s_axis_tready low.
// When the receiver stalls, the estimate word holds and no new item is taken.
module hyperloglog_ipv4_distinct_counter_core #(
  parameter int PRECISION_BITS = hll_pkg::PRECISION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] ip_address
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [30:0] estimate, [31] zero
);

  localparam int P    = PRECISION_BITS;
  localparam int M    = 1 << P;
  localparam int F    = 33 - P;
  localparam int NW   = 2 * P + 46;
  localparam int NWB  = $clog2(NW);
  localparam logic [4:0]    RANK_CAP = 5'(F);
  localparam logic [NW-1:0] NUM      = NW'(7213) << (2 * P + 33);
  localparam logic [NW+1:0] FIVE_M   = (NW + 2)'(5 * M);
  localparam logic [31:0]   K_MUL    = 32'(10 * (1000 * M + 1079));

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001, S_CLR  = 19'h00002, S_H1   = 19'h00004, S_H2   = 19'h00008,
    S_H3   = 19'h00010, S_H4   = 19'h00020, S_WALK = 19'h00040, S_WEND = 19'h00080,
    S_DMUL = 19'h00100, S_DSUM = 19'h00200, S_DIV  = 19'h00400, S_FIN  = 19'h00800,
    S_LOG0 = 19'h01000, S_SQM  = 19'h02000, S_SQU  = 19'h04000, S_LN1  = 19'h08000,
    S_LN2  = 19'h10000, S_LN3  = 19'h20000, S_OUT  = 19'h40000
  } state_t;

  state_t state, state_next;

  logic [4:0]    mem [M];
  logic [4:0]    rdata;
  logic [P-1:0]  raddr;
  logic          we;
  logic [P-1:0]  waddr;
  logic [4:0]    wdata;

  logic [P-1:0]  cnt;
  logic [31:0]   hv;
  logic [63:0]   prod;
  logic [31:0]   mul_a, mul_b;
  logic [P-1:0]  idx;
  logic [4:0]    rank;
  logic          acc_en;
  logic [33:0]   sum;
  logic [P:0]    zeros;
  logic [63:0]   dvs;
  logic [63:0]   rem;
  logic [NW-1:0] quo;
  logic [NWB-1:0] div_idx;
  logic [30:0]   y;
  logic [31:0]   frac;
  logic [4:0]    k_reg;
  logic [4:0]    sq_cnt;
  logic [31:0]   ln_lo;
  logic [30:0]   est;

  // hash finish and rank
  logic [31:0] mix1, mix2, hsh, rest;
  logic [5:0]  lz;
  logic        lz_hit;
  logic [P-1:0] idx_c;
  logic [4:0]  rank_c;

  assign mix1  = hv ^ (hv >> 16);
  assign mix2  = prod[31:0] ^ (prod[31:0] >> 13);
  assign hsh   = prod[31:0] ^ (prod[31:0] >> 16);
  assign idx_c = hsh[31:32-P];
  assign rest  = hsh << P;

  always_comb begin
    lz = '0;
    lz_hit = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!lz_hit && rest[i]) begin
        lz = 6'(31 - i);
        lz_hit = 1'b1;
      end
    end
    if (rest == '0 || (lz + 6'd1) > {1'b0, RANK_CAP}) begin
      rank_c = RANK_CAP;
    end else begin
      rank_c = 5'(lz + 6'd1);
    end
  end

  // walk accumulation term
  logic [4:0]  rk;
  logic [33:0] term;
  assign rk   = (rdata > RANK_CAP) ? RANK_CAP : rdata;
  assign term = 34'd1 << (RANK_CAP - rk);

  // divisor high part
  logic [33:0] khi;
  always_comb begin
    case (sum[33:32])
      2'd1:    khi = {2'b0, K_MUL};
      2'd2:    khi = {1'b0, K_MUL, 1'b0};
      2'd3:    khi = {2'b0, K_MUL} + {1'b0, K_MUL, 1'b0};
      default: khi = '0;
    endcase
  end

  // division step
  logic [63:0] rs;
  assign rs = {rem[62:0], NUM[div_idx]};

  // rounding, small-range test, saturation
  logic [64:0]   rem2;
  logic          rnd;
  logic [NW+1:0] q2;
  logic          lin_range;
  logic [NW:0]   est_full;
  assign rem2      = {rem, 1'b0};
  assign rnd       = rem2 >= {1'b0, dvs};
  assign q2        = {1'b0, quo, 1'b0};
  assign lin_range = (q2 + (NW + 2)'(2) <= FIVE_M) ||
                     ((q2 + (NW + 2)'(1) == FIVE_M) && (rem2 <= {1'b0, dvs})) ||
                     ((q2 == FIVE_M) && (rem == '0));
  assign est_full  = {1'b0, quo} + (NW + 1)'(rnd);

  // log2 of the zero count
  logic [4:0] k_c;
  logic       k_hit;
  always_comb begin
    k_c = '0;
    k_hit = 1'b0;
    for (int i = P; i >= 0; i--) begin
      if (!k_hit && zeros[i]) begin
        k_c = 5'(i);
        k_hit = 1'b1;
      end
    end
  end

  logic [31:0] sq_t;
  logic [36:0] lval;
  logic [63:0] ln_sum, ln_sh;
  assign sq_t   = prod[61:30];
  assign lval   = {5'(P), 32'd0} - {k_reg, frac};
  assign ln_sum = prod + {32'd0, ln_lo};
  assign ln_sh  = (ln_sum << P) + 64'h80000000;

  // shared multiplier operands
  always_comb begin
    case (state)
      S_H1:    begin mul_a = mix1;              mul_b = hll_pkg::HASH_MUL1; end
      S_H2:    begin mul_a = mix2;              mul_b = hll_pkg::HASH_MUL2; end
      S_DMUL:  begin mul_a = sum[31:0];         mul_b = K_MUL;              end
      S_SQM:   begin mul_a = {1'b0, y};         mul_b = {1'b0, y};          end
      S_LN1:   begin mul_a = lval[31:0];        mul_b = hll_pkg::LN2_Q32;   end
      S_LN2:   begin mul_a = {27'd0, lval[36:32]}; mul_b = hll_pkg::LN2_Q32; end
      default: begin mul_a = '0;                mul_b = '0;                 end
    endcase
  end

  // memory port control
  always_comb begin
    raddr = cnt;
    we    = 1'b0;
    waddr = cnt;
    wdata = '0;
    case (state)
      S_H3:    raddr = idx_c;
      S_CLR:   we = 1'b1;
      S_H4: begin
        we    = rank > rdata;
        waddr = idx;
        wdata = rank;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          case (s_axis_tuser)
            hll_pkg::FUNC_ADD:   state_next = S_H1;
            hll_pkg::FUNC_QUERY: state_next = S_WALK;
            hll_pkg::FUNC_CLEAR: state_next = S_CLR;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_CLR:  if (cnt == '1) state_next = S_IDLE;
      S_H1:   state_next = S_H2;
      S_H2:   state_next = S_H3;
      S_H3:   state_next = S_H4;
      S_H4:   state_next = S_IDLE;
      S_WALK: if (cnt == '1) state_next = S_WEND;
      S_WEND: state_next = S_DMUL;
      S_DMUL: state_next = S_DSUM;
      S_DSUM: state_next = S_DIV;
      S_DIV:  if (div_idx == '0) state_next = S_FIN;
      S_FIN:  state_next = (zeros != '0 && lin_range) ? S_LOG0 : S_OUT;
      S_LOG0: state_next = S_SQM;
      S_SQM:  state_next = S_SQU;
      S_SQU:  if (sq_cnt == 5'd31) state_next = S_LN1; else state_next = S_SQM;
      S_LN1:  state_next = S_LN2;
      S_LN2:  state_next = S_LN3;
      S_LN3:  state_next = S_OUT;
      S_OUT:  if (m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLR;
      cnt    <= '0;
      acc_en <= 1'b0;
    end else begin
      state  <= state_next;
      acc_en <= state == S_WALK;
      if (state == S_CLR || state == S_WALK) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (acc_en) begin
      sum   <= sum + term;
      zeros <= zeros + (P + 1)'(rk == '0);
    end
    case (state)
      S_IDLE: begin
        hv    <= s_axis_tdata ^ hll_pkg::HASH_SEED;
        sum   <= '0;
        zeros <= '0;
      end
      S_H3: begin
        idx  <= idx_c;
        rank <= rank_c;
      end
      S_DSUM: begin
        dvs     <= prod + {khi[31:0], 32'd0};
        rem     <= '0;
        quo     <= '0;
        div_idx <= NWB'(NW - 1);
      end
      S_DIV: begin
        if (rs >= dvs) begin
          rem <= rs - dvs;
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= rs;
          quo <= {quo[NW-2:0], 1'b0};
        end
        div_idx <= div_idx - 1'b1;
      end
      S_FIN: begin
        est <= (est_full > (NW + 1)'(hll_pkg::EST_MAX)) ? hll_pkg::EST_MAX : est_full[30:0];
      end
      S_LOG0: begin
        k_reg  <= k_c;
        y      <= 31'({{(30 - P){1'b0}}, zeros} << (5'd30 - k_c));
        frac   <= '0;
        sq_cnt <= '0;
      end
      S_SQU: begin
        if (sq_t[31]) begin
          y    <= sq_t[31:1];
          frac <= {frac[30:0], 1'b1};
        end else begin
          y    <= sq_t[30:0];
          frac <= {frac[30:0], 1'b0};
        end
        sq_cnt <= sq_cnt + 1'b1;
      end
      S_LN2: ln_lo <= prod[63:32];
      S_LN3: begin
        est <= (ln_sh[63:32] > {1'b0, hll_pkg::EST_MAX}) ? hll_pkg::EST_MAX
                                                         : ln_sh[62:32];
      end
      default: ;
    endcase
  end

  assign s_axis_tready = state == S_IDLE;
  assign m_axis_tvalid = state == S_OUT;
  assign m_axis_tdata  = {1'b0, est};

endmodule

>>> design/hll_checker.sv
// Port-level checks for the HyperLogLog distinct counter.
// Bound to hyperloglog_ipv4_distinct_counter_core; no package use.
module hll_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("estimate word dropped or changed while stalled");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while estimate pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("estimate shown right after accept");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !s_axis_tready && !m_axis_tvalid)
    else $error("ready during reset clearing pass");

endmodule

bind hyperloglog_ipv4_distinct_counter_core hll_checker u_hll_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/tb_hyperloglog_ipv4_distinct_counter_core.sv
// Testbench for the HyperLogLog IPv4 distinct counter core.
// Predicts estimates with its own rank store and fixed-point math; uses hll_pkg.
// Drives add, query, clear and unused codes under several idle and stall phases.
module tb_hyperloglog_ipv4_distinct_counter_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PB = hll_pkg::PRECISION_BITS_DEF;
  localparam int NREG = 1 << PB;
  localparam int MAXR = 33 - PB;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  class estimate_scoreboard;
    bit [4:0] ranks [NREG];
    bit [30:0] pending [$];
    int errors;
    int queries;

    function new();
      foreach (ranks[i]) ranks[i] = '0;
      errors = 0;
      queries = 0;
    endfunction

    function bit [31:0] mix(bit [31:0] v);
      v ^= v >> 16;
      v *= hll_pkg::HASH_MUL1;
      v ^= v >> 13;
      v *= hll_pkg::HASH_MUL2;
      v ^= v >> 16;
      return v;
    endfunction

    function bit [63:0] linear_count(bit [31:0] z);
      int k;
      bit [63:0] y, frac, l, ln;
      k = 0;
      frac = 0;
      while (k < 31 && (z >> (k + 1)) != 0) k++;
      y = 64'(z) << (30 - k);
      for (int i = 1; i <= 32; i++) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          y >>= 1;
          frac |= 64'd1 << (32 - i);
        end
      end
      l = (64'(PB) << 32) - ((64'(k) << 32) + frac);
      ln = (l >> 32) * 64'(hll_pkg::LN2_Q32) +
           (((l & 64'hFFFFFFFF) * 64'(hll_pkg::LN2_Q32)) >> 32);
      return (64'(NREG) * ln + (64'd1 << 31)) >> 32;
    endfunction

    function bit [30:0] estimate();
      bit [63:0] total, x, d;
      bit [127:0] num, q, r, est;
      int zeros;
      total = 0;
      zeros = 0;
      for (int i = 0; i < NREG; i++) begin
        if (ranks[i] == 0) zeros++;
        total += 64'd1 << (MAXR - ranks[i]);
      end
      x = 64'd7213 * NREG * NREG * NREG;
      d = 64'd10 * (64'd1000 * NREG + 64'd1079) * total;
      num = 128'(x) << MAXR;
      q = num / d;
      r = num % d;
      est = q + ((2 * r >= 128'(d)) ? 1 : 0);
      if (zeros > 0 && 2 * num <= 128'(5 * NREG) * 128'(d))
        est = 128'(linear_count(32'(zeros)));
      return (est > 128'(hll_pkg::EST_MAX)) ? hll_pkg::EST_MAX : est[30:0];
    endfunction

    function void note_word(bit [1:0] fn, bit [31:0] ip);
      bit [31:0] h, rest;
      int rk;
      case (fn)
        hll_pkg::FUNC_ADD: begin
          h = mix(ip ^ hll_pkg::HASH_SEED);
          rest = h << PB;
          rk = 1;
          if (rest == 0) rk = MAXR;
          else
            while (!rest[31] && rk < MAXR) begin
              rk++;
              rest <<= 1;
            end
          if (rk > ranks[h >> (32 - PB)]) ranks[h >> (32 - PB)] = 5'(rk);
        end
        hll_pkg::FUNC_QUERY: begin
          pending.push_back(estimate());
          queries++;
        end
        hll_pkg::FUNC_CLEAR: foreach (ranks[i]) ranks[i] = '0;
        default: ;
      endcase
    endfunction

    function void check_word(bit [31:0] data);
      bit [30:0] want;
      if (pending.size() == 0) begin
        $error("unexpected estimate word %0d", data);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (data[30:0] !== want) begin
        $error("estimate: expected %0d, actual %0d", want, data[30:0]);
        errors++;
      end
      if (data[31] !== 1'b0) begin
        $error("pad bit: expected 0, actual %0b", data[31]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, m_axis_tready = 0;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic s_axis_tready, m_axis_tvalid;
  logic [31:0] m_axis_tdata;

  int send_idle = 0, recv_stall = 0;
  bit hold_off = 0;
  int word_count = 0;
  estimate_scoreboard sb = new();

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  hyperloglog_ipv4_distinct_counter_core u_top (.*);

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);

  always @(negedge clk) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send_word(bit [1:0] fn, bit [31:0] ip);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= fn;
    s_axis_tdata <= ip;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_word(fn, ip);
    word_count++;
  endtask

  task automatic end_send();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic random_phase(int n, int idle, int stall);
    bit [1:0] fn;
    int sel;
    send_idle = idle;
    recv_stall = stall;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      fn = (sel < 86) ? hll_pkg::FUNC_ADD : (sel < 95) ? hll_pkg::FUNC_QUERY :
           (sel < 98) ? hll_pkg::FUNC_CLEAR : FUNC_UNUSED;
      send_word(fn, (sel & 1) ? $urandom() : $urandom_range(255));
    end
  endtask

  initial begin
    #400000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send_word(hll_pkg::FUNC_QUERY, 0);
    send_word(hll_pkg::FUNC_ADD, 32'h0);
    send_word(hll_pkg::FUNC_ADD, 32'hFFFFFFFF);
    send_word(hll_pkg::FUNC_ADD, hll_pkg::HASH_SEED);
    send_word(hll_pkg::FUNC_ADD, 32'hAAAAAAAA);
    send_word(hll_pkg::FUNC_ADD, 32'h55555555);
    send_word(hll_pkg::FUNC_QUERY, 32'hFFFFFFFF);
    send_word(FUNC_UNUSED, 32'h12345678);
    send_word(hll_pkg::FUNC_CLEAR, 0);
    send_word(hll_pkg::FUNC_QUERY, 0);
    for (int i = 0; i < 12; i++) send_word(hll_pkg::FUNC_ADD, $urandom());
    send_word(hll_pkg::FUNC_QUERY, 0);
    end_send();
    drain();
    // fill a good part of the store
    for (int i = 0; i < 300; i++) send_word(hll_pkg::FUNC_ADD, $urandom());
    send_word(hll_pkg::FUNC_QUERY, 0);
    end_send();
    drain();
    send_word(hll_pkg::FUNC_CLEAR, 0);
    random_phase(230, 0, 0);
    random_phase(230, 68, 0);
    random_phase(230, 0, 68);
    hold_off = 1;
    fork
      begin
        repeat (3000) @(negedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 6; i++) send_word(hll_pkg::FUNC_QUERY, 0);
    join
    end_send();
    drain();
    random_phase(230, 38, 38);
    end_send();
    drain();
    repeat (3000) @(negedge clk);
    $display("covered %0d words and %0d estimates over empty, sparse and busy stores,",
             word_count, sb.queries);
    $display("clears, unused codes, idle senders and long output stalls");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> files.f
design/hll_pkg.sv
design/hyperloglog_ipv4_distinct_counter_core.sv
design/hll_checker.sv
tb/tb_hyperloglog_ipv4_distinct_counter_core.sv
